// File: rtl/pshm_pkg.sv
// Shared types, constants and helpers for the power/self-test health monitor.
// No dependencies; all other source files but pshm_res_if import this package.
package pshm_pkg;

    localparam int unsigned CFG_W    = 20;
    localparam int unsigned DELTA_W  = 16;
    localparam int unsigned OUTAGE_W = 32;
    localparam int unsigned IDX_W    = 2;
    localparam int unsigned NUM_WIN  = 5;
    localparam int unsigned WIN_W    = 16;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_IDX_LONG   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IDX_SHORT  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_IDX_OUTAGE = 2'd2;

    localparam logic [CFG_W-1:0] LONG_TEST_RST   = 20'd40000;
    localparam logic [CFG_W-1:0] SHORT_TEST_RST  = 20'd10000;
    localparam logic [CFG_W-1:0] OUTAGE_FAIL_RST = 20'd10;

    // outage beyond which a recovery test runs long
    localparam logic [OUTAGE_W-1:0] LONG_OUTAGE_MS = 32'd3000;

    // fault light windows, ms since start of a long test, closed ranges
    localparam logic [WIN_W-1:0] WIN_LO [NUM_WIN] = '{16'd0, 16'd13420, 16'd31040,
                                                      16'd31710, 16'd33210};
    localparam logic [WIN_W-1:0] WIN_HI [NUM_WIN] = '{16'd12290, 16'd28670, 16'd31630,
                                                      16'd33130, 16'd35750};

    typedef struct packed {
        logic [DELTA_W-1:0] delta_ms;
        logic               powered;
        logic               fault_injected;
        logic               engage_pressed;
        logic               green_low_press;
        logic               yellow_low_press;
    } t_tick;

    typedef struct packed {
        logic test_done;
        logic fault_light;
        logic monitor_ok;
        logic healthy_out;
        logic supply_fault;
    } t_result;

    typedef struct packed {
        logic [CFG_W-1:0] long_test_ms;
        logic [CFG_W-1:0] short_test_ms;
        logic [CFG_W-1:0] outage_fail_ms;
    } t_cfg;

    typedef struct packed {
        logic [OUTAGE_W-1:0] outage_time;
        logic                supply_fault;
        logic [CFG_W-1:0]    test_timer;
        logic                button_prev;
    } t_state;

    function automatic logic in_light_window(input logic [CFG_W-1:0] elapsed);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_WIN; i++) begin
            if (elapsed >= CFG_W'(WIN_LO[i]) && elapsed <= CFG_W'(WIN_HI[i])) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// File: rtl/pshm_tick_if.sv
// Tick input channel: valid/ready handshake plus the tick fields.
// Depends on pshm_pkg for field widths.
interface pshm_tick_if import pshm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DELTA_W-1:0] delta_ms;
    logic               powered;
    logic               fault_injected;
    logic               engage_pressed;
    logic               green_low_press;
    logic               yellow_low_press;

    modport source (output valid, delta_ms, powered, fault_injected, engage_pressed,
                    green_low_press, yellow_low_press, input ready);
    modport sink   (input valid, delta_ms, powered, fault_injected, engage_pressed,
                    green_low_press, yellow_low_press, output ready);
endinterface

// File: rtl/pshm_res_if.sv
// Result output channel: valid/ready handshake plus the status flags.
// Depends on nothing beyond the pshm_pkg naming conventions.
interface pshm_res_if;
    logic valid;
    logic ready;
    logic test_done;
    logic fault_light;
    logic monitor_ok;
    logic healthy_out;
    logic supply_fault;

    modport source (output valid, test_done, fault_light, monitor_ok, healthy_out,
                    supply_fault, input ready);
    modport sink   (input valid, test_done, fault_light, monitor_ok, healthy_out,
                    supply_fault, output ready);
endinterface

// File: rtl/pshm_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on pshm_pkg for index and data widths.
interface pshm_cfg_if import pshm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/power_selftest_health_monitor_unit.sv
// Top level of the power/self-test health monitor: input register, step logic,
// state and result register. Depends on pshm_pkg, the three channel interfaces,
// pshm_cfg_regs and pshm_step.
//
// Usage:
//  - i_tick carries one tick per transfer (elapsed ms, supply, external fault,
//    engage button, green/yellow low pressure). o_res returns exactly one
//    status transfer per tick, in order.
//  - i_cfg writes long_test_ms (index 0), short_test_ms (1), outage_fail_ms (2);
//    other indexes are dropped. Always ready. Write only while idle.
//  - A tick taken from i_tick goes into the input register; once it moves on,
//    its result is registered in the result register and shown on o_res.
//  - Throughput: one tick per cycle while o_res.ready stays high. All per-tick
//    work (32-bit saturating outage add, threshold compare, timer
//    load/countdown, light windows) sits between the input register and the
//    result/state registers, so the state update closes between them.
//  - Stall: the result register holds while o_res.ready is low; the input
//    register still takes one more tick, then i_tick.ready drops until the
//    result is taken.
//  - Reset (synchronous, active low): both registers empty, outage time,
//    supply fault, timer and button history cleared, registers back to
//    40000 / 10000 / 10 ms.
module power_selftest_health_monitor_unit import pshm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pshm_tick_if.sink  i_tick,
    pshm_cfg_if.sink   i_cfg,
    pshm_res_if.source o_res
);

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_tick   r_in;
    logic    r_in_vld;
    t_result r_out;
    t_result n_out;
    logic    r_out_vld;
    logic    adv;
    logic    tick_acc;

    pshm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    pshm_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_tick   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // the held tick moves on when the result slot is free or being drained
    assign adv          = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_tick.ready = !r_in_vld || adv;
    assign tick_acc     = i_tick.valid && i_tick.ready;

    assign o_res.valid        = r_out_vld;
    assign o_res.test_done    = r_out.test_done;
    assign o_res.fault_light  = r_out.fault_light;
    assign o_res.monitor_ok   = r_out.monitor_ok;
    assign o_res.healthy_out  = r_out.healthy_out;
    assign o_res.supply_fault = r_out.supply_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (tick_acc) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_in.delta_ms         <= i_tick.delta_ms;
            r_in.powered          <= i_tick.powered;
            r_in.fault_injected   <= i_tick.fault_injected;
            r_in.engage_pressed   <= i_tick.engage_pressed;
            r_in.green_low_press  <= i_tick.green_low_press;
            r_in.yellow_low_press <= i_tick.yellow_low_press;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    // a held tick that cannot move on is neither lost nor overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !adv) |=> (r_in_vld && $stable(r_in)))
        else $error("input register lost or changed a pending tick");

    // every tick that moves on shows up as a result next cycle
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_res.valid)
        else $error("step did not produce a result");

    // the light is only lit while a test is running
    a_light_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.fault_light) |-> !o_res.test_done)
        else $error("fault light lit with test done");

    // a latched supply fault keeps monitoring health low
    a_fault_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.supply_fault) |-> !o_res.monitor_ok)
        else $error("monitor ok with supply fault latched");

endmodule

// File: rtl/pshm_cfg_regs.sv
// Configuration register file: three 20-bit duration/threshold registers.
// Depends on pshm_pkg and pshm_cfg_if.
module pshm_cfg_regs import pshm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pshm_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_test_ms   <= LONG_TEST_RST;
            r_cfg.short_test_ms  <= SHORT_TEST_RST;
            r_cfg.outage_fail_ms <= OUTAGE_FAIL_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_IDX_LONG:   r_cfg.long_test_ms   <= i_cfg.data;
                CFG_IDX_SHORT:  r_cfg.short_test_ms  <= i_cfg.data;
                CFG_IDX_OUTAGE: r_cfg.outage_fail_ms <= i_cfg.data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

endmodule

// File: rtl/pshm_step.sv
// Per-tick combinational step: power, button, self-test timer, health.
// Depends on pshm_pkg only.
module pshm_step import pshm_pkg::*; (
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_tick   i_tick,
    output t_state  o_state,
    output t_result o_result
);

    logic [OUTAGE_W:0]   outage_sum;
    logic [OUTAGE_W-1:0] outage_acc;
    logic                fault_set;
    logic                recover;
    logic                both_low;
    logic                btn_edge;
    logic [CFG_W-1:0]    timer_ld;
    logic [CFG_W-1:0]    timer_dec;
    logic [CFG_W:0]      elapsed;
    logic                done;
    logic                light;
    logic                ok;
    logic                fault_nxt;

    always_comb begin
        // power: saturating outage accumulation
        outage_sum = {1'b0, i_state.outage_time} + (OUTAGE_W + 1)'(i_tick.delta_ms);
        if (i_tick.powered) begin
            outage_acc = i_state.outage_time;
        end else if (outage_sum[OUTAGE_W]) begin
            outage_acc = '1;
        end else begin
            outage_acc = outage_sum[OUTAGE_W-1:0];
        end
        fault_set = i_state.supply_fault ||
                    (outage_acc > OUTAGE_W'(i_cfg.outage_fail_ms));
        recover   = i_tick.powered && fault_set;
        fault_nxt = fault_set && !recover;
        both_low  = i_tick.green_low_press && i_tick.yellow_low_press;

        // button edge loads after recovery and wins over it
        btn_edge = i_tick.engage_pressed && !i_state.button_prev && !fault_nxt;
        timer_ld = i_state.test_timer;
        if (recover) begin
            timer_ld = (both_low && outage_acc > LONG_OUTAGE_MS) ?
                       i_cfg.long_test_ms : i_cfg.short_test_ms;
        end
        if (btn_edge) begin
            timer_ld = both_low ? i_cfg.long_test_ms : i_cfg.short_test_ms;
        end

        // countdown, clamped at zero
        timer_dec = (timer_ld > CFG_W'(i_tick.delta_ms)) ?
                    timer_ld - CFG_W'(i_tick.delta_ms) : '0;
        done      = (timer_dec == '0);
        elapsed   = {1'b0, i_cfg.long_test_ms} - {1'b0, timer_dec};
        light     = !done && !elapsed[CFG_W] && in_light_window(elapsed[CFG_W-1:0]);
        ok        = !i_tick.fault_injected && !fault_nxt && done && i_tick.engage_pressed;

        o_state.outage_time  = recover ? '0 : outage_acc;
        o_state.supply_fault = fault_nxt;
        o_state.test_timer   = timer_dec;
        o_state.button_prev  = i_tick.engage_pressed;

        o_result.test_done    = done;
        o_result.fault_light  = light;
        o_result.monitor_ok   = ok;
        o_result.healthy_out  = (done && ok) || (!done && !light);
        o_result.supply_fault = fault_nxt;
    end

endmodule

// File: bench/testbench.sv
// Self-checking bench for power_selftest_health_monitor_unit: tick stream in,
// one status transfer out per tick, checked against an in-bench health model.
// Depends on pshm_pkg and the tick, result and configuration channel interfaces.
module testbench;
    import pshm_pkg::*;

    // index 3 is not a register; writes to it must be dropped
    localparam logic [IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    // Tick-accurate model of the monitor plus the queue of statuses it owes.
    class health_model;
        localparam logic [OUTAGE_W-1:0] RECOVERY_LONG_MS = 32'd3000;

        logic [CFG_W-1:0]    long_ms;
        logic [CFG_W-1:0]    short_ms;
        logic [CFG_W-1:0]    fail_ms;
        logic [OUTAGE_W-1:0] outage_ms;
        logic                fault;
        logic [CFG_W-1:0]    timer_ms;
        logic                btn_prev;
        t_result             expected_status[$];
        int                  mismatches;
        int                  checked;

        function new();
            long_ms     = 20'd40000;
            short_ms    = 20'd10000;
            fail_ms     = 20'd10;
            outage_ms   = '0;
            fault       = 1'b0;
            timer_ms    = '0;
            btn_prev    = 1'b0;
            mismatches  = 0;
            checked     = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_IDX_LONG:   long_ms  = data;
                CFG_IDX_SHORT:  short_ms = data;
                CFG_IDX_OUTAGE: fail_ms  = data;
                default: ;
            endcase
        endfunction

        // no load while the supply fault is latched
        function void load_timer(bit by_button, bit green, bit yellow);
            if (fault) return;
            if (green && yellow && (outage_ms > RECOVERY_LONG_MS || by_button))
                timer_ms = long_ms;
            else
                timer_ms = short_ms;
        endfunction

        function void predict_tick(t_tick t);
            logic [OUTAGE_W:0] sum;
            int                elapsed;
            t_result           r;
            // supply: saturating outage accumulation, latch past the threshold
            if (!t.powered) begin
                sum = {1'b0, outage_ms} + t.delta_ms;
                outage_ms = sum[OUTAGE_W] ? '1 : sum[OUTAGE_W-1:0];
            end
            if (outage_ms > fail_ms) fault = 1'b1;
            if (t.powered && fault) begin
                fault = 1'b0;
                load_timer(1'b0, t.green_low_press, t.yellow_low_press);
                outage_ms = '0;
            end
            // button edge, recorded even when ignored
            if (t.engage_pressed && !btn_prev)
                load_timer(1'b1, t.green_low_press, t.yellow_low_press);
            btn_prev = t.engage_pressed;
            // countdown with clamp
            if (timer_ms != 0)
                timer_ms = (timer_ms > t.delta_ms) ? timer_ms - t.delta_ms : '0;
            r.test_done   = (timer_ms == 0);
            r.fault_light = 1'b0;
            if (!r.test_done) begin
                elapsed = int'(long_ms) - int'(timer_ms);
                r.fault_light = (elapsed >= 0     && elapsed <= 12290) ||
                                (elapsed >= 13420 && elapsed <= 28670) ||
                                (elapsed >= 31040 && elapsed <= 31630) ||
                                (elapsed >= 31710 && elapsed <= 33130) ||
                                (elapsed >= 33210 && elapsed <= 35750);
            end
            r.monitor_ok   = !t.fault_injected && !fault && r.test_done && t.engage_pressed;
            r.healthy_out  = (r.test_done && r.monitor_ok) || (!r.test_done && !r.fault_light);
            r.supply_fault = fault;
            expected_status.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("status %0d: %s", checked, what);
            mismatches++;
        endtask

        task check_status(t_result got);
            t_result want;
            string   names [5];
            names = '{"test_done", "fault_light", "monitor_ok", "healthy_out", "supply_fault"};
            if (expected_status.size() == 0) begin
                report_mismatch($sformatf("status %b with nothing outstanding", got));
                return;
            end
            want = expected_status.pop_front();
            // packed struct: test_done is bit 4 down to supply_fault at bit 0
            for (int i = 0; i < 5; i++) begin
                if (got[4-i] !== want[4-i])
                    report_mismatch($sformatf("%s got %b want %b", names[i],
                                              got[4-i], want[4-i]));
            end
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;

    pshm_tick_if tick_if ();
    pshm_cfg_if  cfg_if ();
    pshm_res_if  res_if ();

    power_selftest_health_monitor_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_tick  (tick_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    health_model board;

    int send_idle_pct;   // chance per cycle that the tick source holds off
    int recv_stall_pct;  // chance per cycle that the status sink holds off
    int hold_cycles;     // long sink hold-off, consumed by the sink process
    int ticks_sent;

    // levels held across ticks of a random sequence
    bit btn_level;
    bit g_level;
    bit y_level;

    // 10 unit clock
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Status sink: ready changes on the falling edge only. A pending
    // hold-off takes precedence over the random stall pattern.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                res_if.ready = 1'b0;
                hold_cycles--;
            end else begin
                res_if.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // every accepted status transfer is checked against the oldest prediction
    always @(posedge clk) begin
        t_result got;
        if (rst_n && res_if.valid && res_if.ready) begin
            got.test_done    = res_if.test_done;
            got.fault_light  = res_if.fault_light;
            got.monitor_ok   = res_if.monitor_ok;
            got.healthy_out  = res_if.healthy_out;
            got.supply_fault = res_if.supply_fault;
            board.check_status(got);
        end
    end

    // Offer one tick; entered and left at a falling edge. Valid stays high
    // after the transfer so back-to-back ticks need no lowering in between.
    task automatic send_tick(input t_tick t);
        while ($urandom_range(99) < send_idle_pct) begin
            tick_if.valid = 1'b0;
            @(negedge clk);
        end
        tick_if.delta_ms         = t.delta_ms;
        tick_if.powered          = t.powered;
        tick_if.fault_injected   = t.fault_injected;
        tick_if.engage_pressed   = t.engage_pressed;
        tick_if.green_low_press  = t.green_low_press;
        tick_if.yellow_low_press = t.yellow_low_press;
        tick_if.valid            = 1'b1;
        @(posedge clk);
        while (!tick_if.ready) @(posedge clk);
        board.predict_tick(t);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic tick(input int d, input bit p, input bit f, input bit b,
                        input bit g, input bit y);
        t_tick t;
        t.delta_ms         = d[DELTA_W-1:0];
        t.powered          = p;
        t.fault_injected   = f;
        t.engage_pressed   = b;
        t.green_low_press  = g;
        t.yellow_low_press = y;
        send_tick(t);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_if.index = idx;
        cfg_if.data  = data;
        cfg_if.valid = 1'b1;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        board.set_reg(idx, data);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // all statuses back, then let the two-stage pipe drain
    task automatic wait_drained();
        tick_if.valid = 1'b0;
        while (board.expected_status.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // mostly small steps so tests run over many ticks; some zero and huge
    function automatic int pick_delta();
        int r;
        r = $urandom_range(99);
        if (r < 5)  return 0;
        if (r < 10) return ($urandom_range(1) != 0) ? 65535 : int'($urandom_range(65535));
        if (r < 70) return $urandom_range(1, 1500);
        return $urandom_range(1500, 5000);
    endfunction

    // One random scenario: a button run, an outage and recovery, or noise.
    task automatic run_sequence();
        int kind;
        kind = $urandom_range(9);
        if (kind < 5) begin
            // both hydraulics low in most runs so long tests and windows are hit
            if ($urandom_range(99) < 60) begin
                g_level = 1'b1;
                y_level = 1'b1;
            end else begin
                g_level = 1'($urandom_range(1));
                y_level = 1'($urandom_range(1));
            end
            btn_level = 1'b1;
            repeat ($urandom_range(2, 40))
                tick(pick_delta(), $urandom_range(99) >= 8, $urandom_range(99) < 15,
                     1'b1, g_level, y_level);
            btn_level = 1'b0;
            repeat ($urandom_range(1, 8))
                tick(pick_delta(), 1'b1, $urandom_range(99) < 15, 1'b0, g_level, y_level);
        end else if (kind < 8) begin
            g_level = ($urandom_range(99) < 70) ? 1'b1 : 1'(int'($urandom_range(1)));
            y_level = ($urandom_range(99) < 70) ? 1'b1 : 1'(int'($urandom_range(1)));
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(99) < 10) btn_level = !btn_level;
                tick(pick_delta(), 1'b0, $urandom_range(99) < 15, btn_level, g_level, y_level);
            end
            repeat ($urandom_range(1, 20)) begin
                if ($urandom_range(99) < 10) btn_level = !btn_level;
                tick(pick_delta(), 1'b1, $urandom_range(99) < 15, btn_level, g_level, y_level);
            end
        end else begin
            repeat ($urandom_range(1, 10)) begin
                btn_level = 1'($urandom_range(1));
                tick($urandom_range(65535), 1'($urandom_range(1)), 1'($urandom_range(1)),
                     btn_level, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    // Reprogram while idle, set the handshake pattern, then random scenarios.
    task automatic run_phase(input logic [CFG_W-1:0] long_ms, input logic [CFG_W-1:0] short_ms,
                             input logic [CFG_W-1:0] fail_ms, input int idle_pct,
                             input int stall_pct, input int n, input bit squeeze);
        int stop_at;
        wait_drained();
        cfg_write(CFG_IDX_UNUSED, CFG_W'($urandom_range(20'hFFFFF)));
        cfg_write(CFG_IDX_LONG, long_ms);
        cfg_write(CFG_IDX_SHORT, short_ms);
        cfg_write(CFG_IDX_OUTAGE, fail_ms);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        // long sink hold-off with the source still pushing: the result
        // register and input register fill and tick ready must drop
        if (squeeze) hold_cycles = 64;
        stop_at = ticks_sent + n;
        while (ticks_sent < stop_at) run_sequence();
    endtask

    initial begin
        board          = new();
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        ticks_sent     = 0;
        btn_level      = 1'b0;
        g_level        = 1'b0;
        y_level        = 1'b0;

        tick_if.valid            = 1'b0;
        tick_if.delta_ms         = '0;
        tick_if.powered          = 1'b0;
        tick_if.fault_injected   = 1'b0;
        tick_if.engage_pressed   = 1'b0;
        tick_if.green_low_press  = 1'b0;
        tick_if.yellow_low_press = 1'b0;
        cfg_if.valid             = 1'b0;
        cfg_if.index             = '0;
        cfg_if.data              = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed ticks on reset settings (40000 / 10000 / 10 ms).
        tick(0, 1, 0, 0, 0, 0);          // idle, timer already zero
        tick(0, 1, 0, 1, 1, 1);          // press, both low: long test, light at start
        tick(12290, 1, 0, 1, 1, 1);      // last ms of first window
        tick(1, 1, 0, 1, 1, 1);          // just past it, light off
        tick(1129, 1, 0, 1, 1, 1);       // start of second window
        tick(15250, 1, 0, 1, 1, 1);      // end of second window
        tick(1, 1, 0, 1, 1, 1);
        tick(2370, 1, 0, 1, 1, 1);       // inside third window
        tick(65535, 1, 0, 1, 1, 1);      // countdown clamps at zero, monitor ok
        tick(0, 1, 1, 1, 1, 1);          // external fault kills monitor ok
        tick(0, 1, 0, 0, 0, 1);          // release
        tick(0, 1, 0, 1, 0, 1);          // press with one side pressurized: short test
        tick(65535, 1, 0, 1, 0, 1);
        tick(10, 0, 0, 0, 1, 1);         // outage equal to threshold, no fault yet
        tick(1, 0, 0, 1, 1, 1);          // outages add up: fault; press ignored
        tick(5, 0, 0, 0, 1, 1);
        tick(0, 1, 0, 0, 1, 1);          // recovery after a short outage: short test
        tick(4000, 1, 0, 0, 1, 1);
        tick(3000, 0, 0, 0, 1, 1);       // outage of exactly 3000 ms
        tick(0, 1, 0, 0, 1, 1);          // recovery: not over 3000, short test
        tick(3001, 0, 0, 0, 1, 1);
        tick(0, 1, 0, 0, 1, 1);          // recovery after a long outage: long test
        tick(65535, 1, 0, 0, 1, 1);
        tick(65535, 1, 0, 1, 1, 1);      // press reloads long, clamps in same tick
        tick(65535, 1, 1, 1, 0, 0);

        // Outage soak: a run of max-length unpowered steps, then recovery
        // must pick the long test.
        wait_drained();
        repeat (8) tick(65535, 0, 0, 0, 1, 1);
        tick(1000, 0, 0, 0, 1, 1);
        tick(0, 1, 0, 0, 1, 1);
        tick(100, 1, 0, 0, 1, 1);

        // Random phases over several register settings and handshake patterns.
        run_phase(20'd40000, 20'd10000, 20'd10, 0, 0, 260, 1'b0);
        run_phase(20'd40000, 20'd10000, 20'd2000, 76, 0, 260, 1'b0);
        run_phase(20'd0, 20'hFFFFF, 20'd0, 0, 76, 250, 1'b0);
        run_phase(20'hFFFFF, 20'd0, 20'hFFFFF, 20, 20, 250, 1'b0);
        run_phase(20'd36000, 20'd30000, 20'd500, 0, 0, 260, 1'b1);
        run_phase(20'd12000, 20'd50000, 20'd3000, 20, 20, 250, 1'b0);

        wait_drained();
        if (board.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/pshm_pkg.sv
rtl/pshm_tick_if.sv
rtl/pshm_res_if.sv
rtl/pshm_cfg_if.sv
rtl/pshm_cfg_regs.sv
rtl/pshm_step.sv
rtl/power_selftest_health_monitor_unit.sv
bench/testbench.sv
